// File: rtl/cstr_pkg.sv
// Package for the console serial and tick register block: codes and constants.
package cstr_pkg;

	localparam int ActionW = 3;
	localparam int SelW    = 3;
	localparam int DataW   = 16;
	localparam int CharW   = 8;
	localparam int SrcW    = 2;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 8;

	// item actions
	localparam logic [ActionW-1:0] ACT_READ     = 3'd0;
	localparam logic [ActionW-1:0] ACT_WRITE    = 3'd1;
	localparam logic [ActionW-1:0] ACT_RX_CHAR  = 3'd2;
	localparam logic [ActionW-1:0] ACT_RX_BREAK = 3'd3;
	localparam logic [ActionW-1:0] ACT_TX_DONE  = 3'd4;
	localparam logic [ActionW-1:0] ACT_TICK     = 3'd5;
	localparam logic [ActionW-1:0] ACT_GRANT    = 3'd6;

	// register selectors
	localparam logic [SelW-1:0] REG_ICCS = 3'd0;
	localparam logic [SelW-1:0] REG_RXCS = 3'd1;
	localparam logic [SelW-1:0] REG_RXDB = 3'd2;
	localparam logic [SelW-1:0] REG_TXCS = 3'd3;
	localparam logic [SelW-1:0] REG_TXDB = 3'd4;

	// interrupt sources
	localparam logic [SrcW-1:0] SRC_CLK = 2'd0;
	localparam logic [SrcW-1:0] SRC_RX  = 2'd1;
	localparam logic [SrcW-1:0] SRC_TX  = 2'd2;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_RX_SEVEN  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_TX_SEVEN  = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_HALT_BRK  = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_HOLD_OFF  = 2'd3;

	localparam int BitDone = 7;
	localparam int BitIe   = 6;

	// error | framing | break
	localparam logic [DataW-1:0] BRK_WORD = 16'h8000 | 16'h2000 | 16'h0400;
	localparam logic [7:0] HOLD_OFF_RESET = 8'd50;
	localparam logic [7:0] AGE_MAX = 8'hFF;

endpackage

// File: rtl/console_serial_and_tick_registers.sv
// Console terminal and interval clock registers: ICCS, RXCS, RXDB, TXCS, TXDB.
// The result word of an accepted word is registered in the output register.
// Throughput: one word per cycle; the input is taken whenever the output register
// is empty or being drained in the same cycle.
// Reset (arst_n low): all flags clear except tx done, which is set; hold-off is 50.
// Configuration writes are taken every cycle.
module console_serial_and_tick_registers
	import cstr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ActionW-1:0]  action,
	input  logic [SelW-1:0]     reg_sel,
	input  logic [DataW-1:0]    write_data,
	input  logic [CharW-1:0]    rx_char,
	input  logic [SrcW-1:0]     ack_source,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DataW-1:0]    read_data,
	output logic                tx_valid,
	output logic [CharW-1:0]    tx_char,
	output logic                rx_accepted,
	output logic                halt_request,
	output logic                tick_ack,
	output logic                clk_irq,
	output logic                rx_irq,
	output logic                tx_irq
);

	typedef struct packed {
		logic [DataW-1:0] read_data;
		logic             tx_valid;
		logic [CharW-1:0] tx_char;
		logic             rx_accepted;
		logic             halt_request;
		logic             tick_ack;
	} result_t;

	logic             rx_seven_q, tx_seven_q, halt_brk_q;
	logic [7:0]       hold_off_q;

	logic [DataW-1:0] rx_buf_q, rx_buf_d;
	logic             rx_done_q, rx_done_d, rx_en_q, rx_en_d, rx_pend_q, rx_pend_d;
	logic [7:0]       rx_age_q, rx_age_d;
	logic [CharW-1:0] tx_buf_q, tx_buf_d;
	logic             tx_done_q, tx_done_d, tx_en_q, tx_en_d, tx_pend_q, tx_pend_d;
	logic             clk_en_q, clk_en_d, clk_pend_q, clk_pend_d;

	result_t          res_d, res_q;
	logic             out_valid_q;
	logic             accept;
	logic             may_load, wr_ie;
	logic [CharW-1:0] rx_masked, tx_masked;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign may_load  = !(rx_done_q && (rx_age_q < hold_off_q));
	assign wr_ie     = write_data[BitIe];
	assign rx_masked = rx_seven_q ? {1'b0, rx_char[CharW-2:0]} : rx_char;
	assign tx_masked = tx_seven_q ? {1'b0, tx_buf_q[CharW-2:0]} : tx_buf_q;

	always_comb begin
		rx_buf_d   = rx_buf_q;
		rx_done_d  = rx_done_q;
		rx_en_d    = rx_en_q;
		rx_pend_d  = rx_pend_q;
		rx_age_d   = rx_age_q;
		tx_buf_d   = tx_buf_q;
		tx_done_d  = tx_done_q;
		tx_en_d    = tx_en_q;
		tx_pend_d  = tx_pend_q;
		clk_en_d   = clk_en_q;
		clk_pend_d = clk_pend_q;
		res_d      = '0;
		unique case (action)
			ACT_READ: begin
				unique case (reg_sel)
					REG_ICCS: res_d.read_data[BitIe] = clk_en_q;
					REG_RXCS: begin
						res_d.read_data[BitDone] = rx_done_q;
						res_d.read_data[BitIe]   = rx_en_q;
					end
					REG_RXDB: begin
						res_d.read_data = rx_buf_q;
						if (rx_done_q) begin
							rx_done_d = 1'b0;
							rx_buf_d  = {8'h00, rx_buf_q[7:0]};
							rx_pend_d = 1'b0;
						end
					end
					REG_TXCS: begin
						res_d.read_data[BitDone] = tx_done_q;
						res_d.read_data[BitIe]   = tx_en_q;
					end
					default: ;
				endcase
			end
			ACT_WRITE: begin
				unique case (reg_sel)
					REG_ICCS: begin
						if (!wr_ie) clk_pend_d = 1'b0;
						res_d.tick_ack = write_data[BitDone];
						clk_en_d = wr_ie;
					end
					REG_RXCS: begin
						if (!wr_ie) rx_pend_d = 1'b0;
						else if (rx_done_q && !rx_en_q) rx_pend_d = 1'b1;
						rx_en_d = wr_ie;
					end
					REG_TXCS: begin
						if (!wr_ie) tx_pend_d = 1'b0;
						else if (tx_done_q && !tx_en_q) tx_pend_d = 1'b1;
						tx_en_d = wr_ie;
					end
					REG_TXDB: begin
						tx_buf_d  = write_data[CharW-1:0];
						tx_done_d = 1'b0;
						tx_pend_d = 1'b0;
					end
					default: ;
				endcase
			end
			ACT_RX_CHAR, ACT_RX_BREAK: begin
				if (may_load) begin
					rx_buf_d  = (action == ACT_RX_BREAK) ? BRK_WORD : {8'h00, rx_masked};
					rx_age_d  = '0;
					rx_done_d = 1'b1;
					if (rx_en_q) rx_pend_d = 1'b1;
					res_d.rx_accepted  = 1'b1;
					res_d.halt_request = (action == ACT_RX_BREAK) && halt_brk_q;
				end
			end
			ACT_TX_DONE: begin
				if (!tx_done_q) begin
					res_d.tx_valid = 1'b1;
					res_d.tx_char  = tx_masked;
					tx_done_d = 1'b1;
					if (tx_en_q) tx_pend_d = 1'b1;
				end
			end
			ACT_TICK: begin
				if (clk_en_q) clk_pend_d = 1'b1;
				if (rx_age_q != AGE_MAX) rx_age_d = rx_age_q + 8'd1;
			end
			ACT_GRANT: begin
				unique case (ack_source)
					SRC_CLK: clk_pend_d = 1'b0;
					SRC_RX:  rx_pend_d  = 1'b0;
					SRC_TX:  tx_pend_d  = 1'b0;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_seven_q <= 1'b0;
			tx_seven_q <= 1'b0;
			halt_brk_q <= 1'b0;
			hold_off_q <= HOLD_OFF_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_RX_SEVEN: rx_seven_q <= cfg_data[0];
				CFG_TX_SEVEN: tx_seven_q <= cfg_data[0];
				CFG_HALT_BRK: halt_brk_q <= cfg_data[0];
				CFG_HOLD_OFF: hold_off_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_buf_q    <= '0;
			rx_done_q   <= 1'b0;
			rx_en_q     <= 1'b0;
			rx_pend_q   <= 1'b0;
			rx_age_q    <= '0;
			tx_buf_q    <= '0;
			tx_done_q   <= 1'b1;
			tx_en_q     <= 1'b0;
			tx_pend_q   <= 1'b0;
			clk_en_q    <= 1'b0;
			clk_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				rx_buf_q   <= rx_buf_d;
				rx_done_q  <= rx_done_d;
				rx_en_q    <= rx_en_d;
				rx_pend_q  <= rx_pend_d;
				rx_age_q   <= rx_age_d;
				tx_buf_q   <= tx_buf_d;
				tx_done_q  <= tx_done_d;
				tx_en_q    <= tx_en_d;
				tx_pend_q  <= tx_pend_d;
				clk_en_q   <= clk_en_d;
				clk_pend_q <= clk_pend_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word register; request levels come from the live flags,
	// which only change when the next word is taken
	always_ff @(posedge clk) begin
		if (accept) res_q <= res_d;
	end

	assign out_valid    = out_valid_q;
	assign read_data    = res_q.read_data;
	assign tx_valid     = res_q.tx_valid;
	assign tx_char      = res_q.tx_char;
	assign rx_accepted  = res_q.rx_accepted;
	assign halt_request = res_q.halt_request;
	assign tick_ack     = res_q.tick_ack;
	assign clk_irq      = clk_pend_q;
	assign rx_irq       = rx_pend_q;
	assign tx_irq       = tx_pend_q;

endmodule
